// ----- rtl/plde_pkg.sv -----
// Shared types and constants for the prey lattice density engine.
// No dependencies; every other file of the block imports this package.
package plde_pkg;

    localparam int DEF_MAX_ROWS   = 128;
    localparam int DEF_MAX_COLS   = 128;
    localparam int DEF_MAX_RADIUS = 3;

    // Widths of the command that passes from the front part to the back part.
    // They cover the largest lattice and radius that the parameters allow.
    localparam int CMD_IDX_W = 10;
    localparam int CMD_DIM_W = 11;
    localparam int CMD_RAD_W = 3;
    localparam int Q_DEPTH   = 2;
    localparam int ROW_IN_W  = 7;

    localparam logic [7:0]  RST_GRID_ROWS   = 8'd128;
    localparam logic [7:0]  RST_GRID_COLS   = 8'd128;
    localparam logic [1:0]  RST_RADIUS      = 2'd1;
    localparam logic [15:0] RST_COMP_FACTOR = 16'd4096;

    localparam logic [1:0] REG_GRID_ROWS   = 2'd0;
    localparam logic [1:0] REG_GRID_COLS   = 2'd1;
    localparam logic [1:0] REG_RADIUS      = 2'd2;
    localparam logic [1:0] REG_COMP_FACTOR = 2'd3;

    typedef enum logic [1:0] {
        ACT_ADD,
        ACT_REMOVE,
        ACT_COMPETE,
        ACT_SNAPSHOT
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [6:0]  cell_row;
        logic [6:0]  cell_col;
        logic [15:0] random_value;
    } item_t;

    typedef struct packed {
        logic        prey_present;
        logic        cell_changed;
        logic [5:0]  cell_density;
        logic [14:0] prey_total;
    } result_t;

    typedef struct packed {
        action_t                action;
        logic [CMD_IDX_W-1:0]   row;
        logic [CMD_IDX_W-1:0]   col;
        logic [CMD_DIM_W-1:0]   rows;
        logic [CMD_DIM_W-1:0]   cols;
        logic [CMD_RAD_W-1:0]   rad;
        logic [7:0]             nbr_n;
        logic [15:0]            rnd;
        logic [15:0]            factor;
    } cmd_t;

endpackage

// ----- rtl/prey_lattice_density_engine_unit.sv -----
// Top level of the prey lattice density engine: configuration registers,
// front part, command queue and back part. Depends on plde_pkg.
//
// Use: an item is taken on the rising edge where start is high and busy is
// low. Every item gives exactly one result beat, shown on result for one
// cycle with done high; the receiver cannot hold it off, and results come in
// the order the items were taken.
// The front part takes seven remainder steps for the modulo reduction of
// row and column, then hands the command to the queue, waiting while it is
// full; the two-entry queue lets it take a further item while the back part
// works. In the back part a missed add, remove or competition test reads the
// cell and then reads it again for the result; a competition test on a
// present prey first forms and checks the products. A change of prey bit
// adds R steps to align the neighbour walk, a pipelined read-modify-write
// over the (2R+1)^2 offsets, one a cycle, and a drain of the pipeline. A
// snapshot is a sweep over the whole cell memory, then a drain.
// After reset the back part clears both memories, one entry a cycle, over
// all MAX_ROWS*MAX_COLS entries; busy is high meanwhile.
// Configuration writes go through the APB port; the user must make them only
// while the block is idle, as the block itself does not enforce this.
module prey_lattice_density_engine_unit #(
    parameter int MAX_ROWS   = plde_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = plde_pkg::DEF_MAX_COLS,
    parameter int MAX_RADIUS = plde_pkg::DEF_MAX_RADIUS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  plde_pkg::item_t   item,
    output logic              done,
    output plde_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import plde_pkg::*;

    logic [7:0]  grid_rows_reg;
    logic [7:0]  grid_cols_reg;
    logic [1:0]  radius_reg;
    logic [15:0] factor_reg;

    logic        cfg_write;
    logic [1:0]  reg_index;

    logic        clearing;
    logic        push;
    logic        pop;
    logic        full;
    logic        not_empty;
    cmd_t        front_cmd;
    cmd_t        head_cmd;

    // The APB port never inserts wait states.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= RST_GRID_ROWS;
            grid_cols_reg <= RST_GRID_COLS;
            radius_reg    <= RST_RADIUS;
            factor_reg    <= RST_COMP_FACTOR;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_GRID_ROWS:   grid_rows_reg <= pwdata[7:0];
                REG_GRID_COLS:   grid_cols_reg <= pwdata[7:0];
                REG_RADIUS:      radius_reg    <= pwdata[1:0];
                REG_COMP_FACTOR: factor_reg    <= pwdata[15:0];
                default:         grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_GRID_ROWS:   prdata = {24'd0, grid_rows_reg};
            REG_GRID_COLS:   prdata = {24'd0, grid_cols_reg};
            REG_RADIUS:      prdata = {30'd0, radius_reg};
            REG_COMP_FACTOR: prdata = {16'd0, factor_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // The front part clamps the configuration and reduces the address.
    plde_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .hold               (clearing),
        .item               (item),
        .grid_rows          (grid_rows_reg),
        .grid_cols          (grid_cols_reg),
        .fitness_radius     (radius_reg),
        .competition_factor (factor_reg),
        .full               (full),
        .busy               (busy),
        .push               (push),
        .cmd                (front_cmd)
    );

    // The queue lets the front part take the next beat while the back works.
    plde_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .full      (full),
        .not_empty (not_empty)
    );

    // The back part owns the lattice memories and issues the result beats.
    plde_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (not_empty),
        .cmd_in   (head_cmd),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule

// ----- rtl/plde_front.sv -----
// Front part: takes an item, clamps the configuration and reduces the cell
// address modulo the lattice size bit by bit. Depends on plde_pkg.
module plde_front #(
    parameter int MAX_ROWS   = plde_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = plde_pkg::DEF_MAX_COLS,
    parameter int MAX_RADIUS = plde_pkg::DEF_MAX_RADIUS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             hold,
    input  plde_pkg::item_t  item,
    input  logic [7:0]       grid_rows,
    input  logic [7:0]       grid_cols,
    input  logic [1:0]       fitness_radius,
    input  logic [15:0]      competition_factor,
    input  logic             full,
    output logic             busy,
    output logic             push,
    output plde_pkg::cmd_t   cmd
);
    import plde_pkg::*;

    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int STEP_W = $clog2(ROW_IN_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } front_state_t;

    front_state_t        state_reg;
    item_t               item_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic [COLS_W-1:0]   cols_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [15:0]         factor_reg;
    logic [ROWS_W-1:0]   rem_r_reg;
    logic [COLS_W-1:0]   rem_c_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [ROWS_W-1:0]   rows_clamp;
    logic [COLS_W-1:0]   cols_clamp;
    logic [RAD_W-1:0]    rad_clamp;
    logic [ROWS_W:0]     trial_r;
    logic [COLS_W:0]     trial_c;
    logic [ROWS_W-1:0]   rem_r_next;
    logic [COLS_W-1:0]   rem_c_next;
    logic [3:0]          span;
    logic                accept;

    assign accept = start && !hold && (state_reg == ST_IDLE);
    assign busy   = hold || (state_reg != ST_IDLE);
    assign push   = (state_reg == ST_PUSH) && !full;

    always_comb
    begin
        if (grid_rows == 8'd0)
            rows_clamp = ROWS_W'(1);
        else if (32'(grid_rows) > 32'(MAX_ROWS))
            rows_clamp = ROWS_W'(MAX_ROWS);
        else
            rows_clamp = ROWS_W'(grid_rows);

        if (grid_cols == 8'd0)
            cols_clamp = COLS_W'(1);
        else if (32'(grid_cols) > 32'(MAX_COLS))
            cols_clamp = COLS_W'(MAX_COLS);
        else
            cols_clamp = COLS_W'(grid_cols);

        if (fitness_radius == 2'd0)
            rad_clamp = RAD_W'(1);
        else if (32'(fitness_radius) > 32'(MAX_RADIUS))
            rad_clamp = RAD_W'(MAX_RADIUS);
        else
            rad_clamp = RAD_W'(fitness_radius);
    end

    // One restoring-remainder step per cycle on each coordinate.
    always_comb
    begin
        trial_r = {rem_r_reg, item_reg.cell_row[step_reg]};
        trial_c = {rem_c_reg, item_reg.cell_col[step_reg]};
        if (trial_r >= {1'b0, rows_reg})
            rem_r_next = ROWS_W'(trial_r - {1'b0, rows_reg});
        else
            rem_r_next = ROWS_W'(trial_r);
        if (trial_c >= {1'b0, cols_reg})
            rem_c_next = COLS_W'(trial_c - {1'b0, cols_reg});
        else
            rem_c_next = COLS_W'(trial_c);
    end

    assign span = 4'(32'(rad_reg) * 2 + 1);

    always_comb
    begin
        cmd.action = item_reg.action;
        cmd.row    = CMD_IDX_W'(rem_r_reg);
        cmd.col    = CMD_IDX_W'(rem_c_reg);
        cmd.rows   = CMD_DIM_W'(rows_reg);
        cmd.cols   = CMD_DIM_W'(cols_reg);
        cmd.rad    = CMD_RAD_W'(rad_reg);
        cmd.nbr_n  = 8'(32'(span) * 32'(span) - 1);
        cmd.rnd    = item_reg.random_value;
        cmd.factor = factor_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg   <= item;
                        rows_reg   <= rows_clamp;
                        cols_reg   <= cols_clamp;
                        rad_reg    <= rad_clamp;
                        factor_reg <= competition_factor;
                        rem_r_reg  <= '0;
                        rem_c_reg  <= '0;
                        step_reg   <= STEP_W'(ROW_IN_W - 1);
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_r_reg <= rem_r_next;
                    rem_c_reg <= rem_c_next;
                    step_reg  <= step_reg - STEP_W'(1);
                    if (step_reg == '0)
                        state_reg <= ST_PUSH;
                end
                ST_PUSH:
                begin
                    if (!full)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/plde_queue.sv -----
// Short command queue between the front and back parts.
// Depends on plde_pkg for the command type and depth.
module plde_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  plde_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output plde_pkg::cmd_t  head,
    output logic            full,
    output logic            not_empty
);
    import plde_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t               slot_reg [0:Q_DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign head      = slot_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ----- rtl/plde_back.sv -----
// Back part: owns the cell and snapshot memories, carries out each command
// and produces the result beat. Depends on plde_pkg.
module plde_back #(
    parameter int MAX_ROWS   = plde_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = plde_pkg::DEF_MAX_COLS,
    parameter int MAX_RADIUS = plde_pkg::DEF_MAX_RADIUS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  plde_pkg::cmd_t    cmd_in,
    output logic              pop,
    output logic              clearing,
    output logic              done,
    output plde_pkg::result_t result
);
    import plde_pkg::*;

    localparam int IR_W   = $clog2(MAX_ROWS);
    localparam int IC_W   = $clog2(MAX_COLS);
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W  = $clog2(2 * MAX_RADIUS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_WAIT,
        ST_CMP_MUL,
        ST_CMP_CHK,
        ST_ALIGN,
        ST_WALK,
        ST_DRAIN,
        ST_FINAL_RD,
        ST_FINAL_WAIT,
        ST_SNAP,
        ST_SNAP_DRAIN
    } back_state_t;

    // Cell word: prey bit on top of the live neighbour count.
    logic [6:0] cell_mem [0:CELLS-1];
    logic [5:0] snap_mem [0:CELLS-1];

    back_state_t        state_reg;
    cmd_t               cmd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [IR_W-1:0]    nr_reg;
    logic [IC_W-1:0]    nc_reg;
    logic [IC_W-1:0]    nc0_reg;
    logic [OFS_W-1:0]   dy_reg;
    logic [OFS_W-1:0]   dx_reg;
    logic [RAD_W-1:0]   align_reg;
    logic               lower_reg;
    logic               changed_reg;
    logic [5:0]         cnt_reg;
    logic [5:0]         snap_reg;
    logic [23:0]        lhs_reg;
    logic [21:0]        rhs_reg;
    logic [14:0]        prey_count_reg;
    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               lw_valid_reg;
    logic [ADDR_W-1:0]  lw_addr_reg;
    logic [6:0]         lw_data_reg;
    logic [ADDR_W-1:0]  sweep_reg;
    logic               sw_valid_reg;
    logic [ADDR_W-1:0]  sw_addr_reg;
    logic               done_reg;
    result_t            result_reg;

    logic [6:0]         cm_q;
    logic [5:0]         sn_q;
    logic               cm_we;
    logic [ADDR_W-1:0]  cm_waddr;
    logic [6:0]         cm_wdata;
    logic [ADDR_W-1:0]  cm_raddr;
    logic               sn_we;
    logic [ADDR_W-1:0]  sn_waddr;
    logic [5:0]         sn_wdata;

    logic [IR_W-1:0]    rows_last;
    logic [IC_W-1:0]    cols_last;
    logic [IR_W-1:0]    nr_inc;
    logic [IR_W-1:0]    nr_dec;
    logic [IC_W-1:0]    nc_inc;
    logic [IC_W-1:0]    nc_dec;
    logic [RAD_W-1:0]   rad_w;
    logic [OFS_W-1:0]   span;
    logic               centre;
    logic [ADDR_W-1:0]  nbr_addr;
    logic [ADDR_W-1:0]  head_addr;
    logic [6:0]         s1_word;
    logic [5:0]         s1_cnt;
    logic               kill;
    logic [ADDR_W-1:0]  last_addr;

    assign last_addr = ADDR_W'(CELLS - 1);
    assign rows_last = IR_W'(cmd_reg.rows - CMD_DIM_W'(1));
    assign cols_last = IC_W'(cmd_reg.cols - CMD_DIM_W'(1));
    assign nr_inc    = (nr_reg == rows_last) ? '0 : nr_reg + IR_W'(1);
    assign nr_dec    = (nr_reg == '0) ? rows_last : nr_reg - IR_W'(1);
    assign nc_inc    = (nc_reg == cols_last) ? '0 : nc_reg + IC_W'(1);
    assign nc_dec    = (nc_reg == '0) ? cols_last : nc_reg - IC_W'(1);
    assign rad_w     = RAD_W'(cmd_reg.rad);
    assign span      = OFS_W'(32'(rad_w) * 2);
    assign centre    = (dy_reg == OFS_W'(rad_w)) && (dx_reg == OFS_W'(rad_w));
    assign nbr_addr  = ADDR_W'(32'(nr_reg) * 32'(MAX_COLS) + 32'(nc_reg));
    assign head_addr = ADDR_W'(32'(cmd_in.row) * 32'(MAX_COLS) + 32'(cmd_in.col));
    assign kill      = {2'b00, lhs_reg} <= {rhs_reg, 4'b0000};

    // A read issued in the same cycle as a write to that entry sees old data.
    assign s1_word = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : cm_q;

    always_comb
    begin
        if (lower_reg)
            s1_cnt = (s1_word[5:0] != 6'd0) ? s1_word[5:0] - 6'd1 : s1_word[5:0];
        else
            s1_cnt = (s1_word[5:0] != 6'd63) ? s1_word[5:0] + 6'd1 : s1_word[5:0];
    end

    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign clearing = (state_reg == ST_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

    always_comb
    begin
        cm_we    = 1'b0;
        cm_waddr = addr_reg;
        cm_wdata = 7'd0;
        cm_raddr = addr_reg;
        sn_we    = 1'b0;
        sn_waddr = sw_addr_reg;
        sn_wdata = cm_q[5:0];
        case (state_reg)
            ST_CLEAR:
            begin
                cm_we    = 1'b1;
                cm_waddr = sweep_reg;
                sn_we    = 1'b1;
                sn_waddr = sweep_reg;
                sn_wdata = 6'd0;
            end
            ST_CELL_WAIT:
            begin
                if ((cmd_reg.action == ACT_ADD) && !cm_q[6])
                begin
                    cm_we    = 1'b1;
                    cm_wdata = {1'b1, cm_q[5:0]};
                end
                else if ((cmd_reg.action == ACT_REMOVE) && cm_q[6])
                begin
                    cm_we    = 1'b1;
                    cm_wdata = {1'b0, cm_q[5:0]};
                end
            end
            ST_CMP_CHK:
            begin
                cm_we    = kill;
                cm_wdata = {1'b0, cnt_reg};
            end
            ST_WALK:
                cm_raddr = nbr_addr;
            ST_SNAP:
            begin
                cm_raddr = sweep_reg;
                sn_we    = sw_valid_reg;
            end
            ST_SNAP_DRAIN:
                sn_we = sw_valid_reg;
            default:
                cm_raddr = addr_reg;
        endcase
        if (s1_valid_reg)
        begin
            cm_we    = 1'b1;
            cm_waddr = s1_addr_reg;
            cm_wdata = {s1_word[6], s1_cnt};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
            cell_mem[cm_waddr] <= cm_wdata;
        cm_q <= cell_mem[cm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sn_we)
            snap_mem[sn_waddr] <= sn_wdata;
        sn_q <= snap_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            prey_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            sw_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
            changed_reg    <= 1'b0;
            lower_reg      <= 1'b0;
        end
        else
        begin
            done_reg     <= (state_reg == ST_FINAL_WAIT);
            s1_valid_reg <= (state_reg == ST_WALK) && !centre;
            s1_addr_reg  <= nbr_addr;
            lw_valid_reg <= s1_valid_reg;
            lw_addr_reg  <= s1_addr_reg;
            lw_data_reg  <= {s1_word[6], s1_cnt};
            sw_valid_reg <= (state_reg == ST_SNAP);
            sw_addr_reg  <= sweep_reg;
            case (state_reg)
                ST_CLEAR:
                begin
                    if (sweep_reg == last_addr)
                    begin
                        sweep_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                        sweep_reg <= sweep_reg + ADDR_W'(1);
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg     <= cmd_in;
                        addr_reg    <= head_addr;
                        changed_reg <= 1'b0;
                        state_reg   <= ST_CELL_RD;
                    end
                end
                ST_CELL_RD:
                    state_reg <= ST_CELL_WAIT;
                ST_CELL_WAIT:
                begin
                    cnt_reg   <= cm_q[5:0];
                    snap_reg  <= sn_q;
                    nr_reg    <= IR_W'(cmd_reg.row);
                    nc_reg    <= IC_W'(cmd_reg.col);
                    align_reg <= rad_w;
                    dy_reg    <= '0;
                    dx_reg    <= '0;
                    case (cmd_reg.action)
                        ACT_ADD:
                        begin
                            if (!cm_q[6])
                            begin
                                if (prey_count_reg != 15'h7FFF)
                                    prey_count_reg <= prey_count_reg + 15'd1;
                                changed_reg <= 1'b1;
                                lower_reg   <= 1'b0;
                                state_reg   <= ST_ALIGN;
                            end
                            else
                                state_reg <= ST_FINAL_RD;
                        end
                        ACT_REMOVE:
                        begin
                            if (cm_q[6])
                            begin
                                if (prey_count_reg != 15'd0)
                                    prey_count_reg <= prey_count_reg - 15'd1;
                                changed_reg <= 1'b1;
                                lower_reg   <= 1'b1;
                                state_reg   <= ST_ALIGN;
                            end
                            else
                                state_reg <= ST_FINAL_RD;
                        end
                        ACT_COMPETE:
                        begin
                            if (cm_q[6])
                                state_reg <= ST_CMP_MUL;
                            else
                                state_reg <= ST_FINAL_RD;
                        end
                        ACT_SNAPSHOT:
                        begin
                            sweep_reg <= '0;
                            state_reg <= ST_SNAP;
                        end
                        default:
                            state_reg <= ST_FINAL_RD;
                    endcase
                end
                ST_CMP_MUL:
                begin
                    lhs_reg   <= 24'(cmd_reg.rnd) * 24'(cmd_reg.nbr_n);
                    rhs_reg   <= 22'(snap_reg) * 22'(cmd_reg.factor);
                    state_reg <= ST_CMP_CHK;
                end
                ST_CMP_CHK:
                begin
                    if (kill)
                    begin
                        if (prey_count_reg != 15'd0)
                            prey_count_reg <= prey_count_reg - 15'd1;
                        changed_reg <= 1'b1;
                        lower_reg   <= 1'b1;
                        state_reg   <= ST_ALIGN;
                    end
                    else
                        state_reg <= ST_FINAL_RD;
                end
                ST_ALIGN:
                begin
                    nr_reg    <= nr_dec;
                    nc_reg    <= nc_dec;
                    align_reg <= align_reg - RAD_W'(1);
                    if (align_reg == RAD_W'(1))
                    begin
                        nc0_reg   <= nc_dec;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (dx_reg == span)
                    begin
                        dx_reg <= '0;
                        nc_reg <= nc0_reg;
                        if (dy_reg == span)
                            state_reg <= ST_DRAIN;
                        else
                        begin
                            dy_reg <= dy_reg + OFS_W'(1);
                            nr_reg <= nr_inc;
                        end
                    end
                    else
                    begin
                        dx_reg <= dx_reg + OFS_W'(1);
                        nc_reg <= nc_inc;
                    end
                end
                ST_DRAIN:
                    state_reg <= ST_FINAL_RD;
                ST_SNAP:
                begin
                    sweep_reg <= sweep_reg + ADDR_W'(1);
                    if (sweep_reg == last_addr)
                        state_reg <= ST_SNAP_DRAIN;
                end
                ST_SNAP_DRAIN:
                    state_reg <= ST_FINAL_RD;
                ST_FINAL_RD:
                    state_reg <= ST_FINAL_WAIT;
                ST_FINAL_WAIT:
                begin
                    result_reg.prey_present <= cm_q[6];
                    result_reg.cell_changed <= changed_reg;
                    result_reg.cell_density <= cm_q[5:0];
                    result_reg.prey_total   <= prey_count_reg;
                    state_reg               <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/plde_check.sv -----
// Port-level checker for the prey lattice density engine, bound to the top
// level. Depends on plde_pkg and prey_lattice_density_engine_unit.
module plde_check (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input plde_pkg::item_t   item,
    input logic              done,
    input plde_pkg::result_t result,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [3:0]        paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);
    import plde_pkg::*;

    // A taken beat always keeps the front part occupied for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low straight after an accepted beat");

    // Every result passes through the whole back-part sequence, so result beats never come back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats in consecutive cycles");

    // A change of the prey bit always leaves the total at or below the lattice.
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.prey_total <= 15'd16384 || !result.cell_changed ||
                  result.prey_total == 15'h7FFF))
        else $error("prey total out of range");

    // Read data only carries the register bits.
    a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:16] == 16'd0)
        else $error("register read data has upper bits set");

endmodule

bind prey_lattice_density_engine_unit plde_check u_check (.*);

// ----- bench/plde_checker.sv -----
// Checker for the prey lattice density engine: keeps its own lattice, counts and registers,
// predicts one result per accepted item and compares each result beat field by field.
// Depends on plde_pkg.
module plde_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  plde_pkg::item_t   item,
    input  logic              done,
    input  plde_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output int                fails,
    output int                pending
);
    import plde_pkg::*;

    localparam int N_ROWS  = DEF_MAX_ROWS;
    localparam int N_COLS  = DEF_MAX_COLS;
    localparam int N_RAD   = DEF_MAX_RADIUS;
    localparam int N_CELLS = N_ROWS * N_COLS;

    logic [7:0]  rows_reg;
    logic [7:0]  cols_reg;
    logic [1:0]  radius_reg;
    logic [15:0] factor_reg;

    bit         prey_bit [N_CELLS];
    logic [5:0] live_cnt [N_CELLS];
    logic [5:0] snap_cnt [N_CELLS];
    int         prey_sum;

    result_t    expected_results [$];

    assign pending = expected_results.size();

    // Raises or lowers the neighbour counts around a cell, with wrap-around and saturation.
    task automatic shift_neighbours(input int row, input int col, input int rows,
                                    input int cols, input int rad, input bit lower);
        int nr;
        int nc;
        int a;
        for (int dy = -rad; dy <= rad; dy++)
        begin
            for (int dx = -rad; dx <= rad; dx++)
            begin
                if (dy == 0 && dx == 0)
                    continue;
                nr = ((row + dy) % rows + rows) % rows;
                nc = ((col + dx) % cols + cols) % cols;
                a  = nr * N_COLS + nc;
                if (lower)
                begin
                    if (live_cnt[a] != 0)
                        live_cnt[a] = live_cnt[a] - 1;
                end
                else if (live_cnt[a] != 6'd63)
                    live_cnt[a] = live_cnt[a] + 1;
            end
        end
    endtask

    task automatic predict_step(input item_t it);
        int      rows;
        int      cols;
        int      rad;
        int      row;
        int      col;
        int      a;
        bit      kill;
        bit      changed;
        longint  lhs;
        longint  rhs;
        result_t r;
        rows = (rows_reg == 0) ? 1 : (rows_reg > N_ROWS ? N_ROWS : int'(rows_reg));
        cols = (cols_reg == 0) ? 1 : (cols_reg > N_COLS ? N_COLS : int'(cols_reg));
        rad  = (radius_reg == 0) ? 1 : (radius_reg > N_RAD ? N_RAD : int'(radius_reg));
        row  = int'(it.cell_row) % rows;
        col  = int'(it.cell_col) % cols;
        a    = row * N_COLS + col;
        kill = 0;
        changed = 0;
        case (it.action)
            ACT_ADD:
            begin
                if (!prey_bit[a])
                begin
                    prey_bit[a] = 1;
                    shift_neighbours(row, col, rows, cols, rad, 0);
                    if (prey_sum < 32767)
                        prey_sum++;
                    changed = 1;
                end
            end
            ACT_REMOVE:
                kill = prey_bit[a];
            ACT_COMPETE:
            begin
                if (prey_bit[a])
                begin
                    lhs  = longint'(it.random_value) * longint'((2 * rad + 1) * (2 * rad + 1) - 1);
                    rhs  = longint'(snap_cnt[a]) * longint'(factor_reg) * 16;
                    kill = (lhs <= rhs);
                end
            end
            default:
                snap_cnt = live_cnt;
        endcase
        if (kill)
        begin
            prey_bit[a] = 0;
            shift_neighbours(row, col, rows, cols, rad, 1);
            if (prey_sum > 0)
                prey_sum--;
            changed = 1;
        end
        r.prey_present = prey_bit[a];
        r.cell_changed = changed;
        r.cell_density = live_cnt[a];
        r.prey_total   = prey_sum[14:0];
        expected_results = {expected_results, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= RST_GRID_ROWS;
            cols_reg   <= RST_GRID_COLS;
            radius_reg <= RST_RADIUS;
            factor_reg <= RST_COMP_FACTOR;
            for (int i = 0; i < N_CELLS; i++)
            begin
                prey_bit[i] = 0;
                live_cnt[i] = '0;
                snap_cnt[i] = '0;
            end
            prey_sum = 0;
            fails    = 0;
            expected_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_GRID_ROWS:   rows_reg   <= pwdata[7:0];
                    REG_GRID_COLS:   cols_reg   <= pwdata[7:0];
                    REG_RADIUS:      radius_reg <= pwdata[1:0];
                    REG_COMP_FACTOR: factor_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: %p", $time, result);
                    fails++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (e.prey_present !== result.prey_present)
                    begin
                        $display("%0t: prey_present expected %0d actual %0d",
                                 $time, e.prey_present, result.prey_present);
                        fails++;
                    end
                    if (e.cell_changed !== result.cell_changed)
                    begin
                        $display("%0t: cell_changed expected %0d actual %0d",
                                 $time, e.cell_changed, result.cell_changed);
                        fails++;
                    end
                    if (e.cell_density !== result.cell_density)
                    begin
                        $display("%0t: cell_density expected %0d actual %0d",
                                 $time, e.cell_density, result.cell_density);
                        fails++;
                    end
                    if (e.prey_total !== result.prey_total)
                    begin
                        $display("%0t: prey_total expected %0d actual %0d",
                                 $time, e.prey_total, result.prey_total);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                predict_step(item);
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the prey lattice density engine testbench: clock, reset, stimulus and verdict.
// Depends on plde_pkg, plde_checker and the unit under test.
module tb_top;
    import plde_pkg::*;

    // A snapshot or the clearing pass after reset sweeps the whole memory without a
    // beat, so the watchdog allows several times such a sweep before it calls the run dead.
    localparam int WATCHDOG_LIMIT = 120000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fails;
    int          pending;
    int          quiet_cycles;

    prey_lattice_density_engine_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    plde_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .fails(fails), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The watchdog counts cycles in which neither an item nor a result beat is taken.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Every task below is entered and left at a falling edge.
    task automatic wait_drained();
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drives one item with an optional gap in front of it. Start stays high
    // between back-to-back items; the beat is taken at the first rising edge
    // at which busy is low.
    task automatic send_item(input action_t act, input int row, input int col,
                             input int rnd, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.action       <= act;
        item.cell_row     <= row[6:0];
        item.cell_col     <= col[6:0];
        item.random_value <= rnd[15:0];
        start             <= 1'b1;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_lattice(input int rows, input int cols, input int rad, input int factor);
        start <= 1'b0;
        wait_drained();
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_GRID_COLS, cols);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_COMP_FACTOR, factor);
    endtask

    // Random phase. Most items land in a small window of the lattice so that
    // neighbourhoods overlap; competition values are often small so that
    // tests hit as well as miss. Snapshots are rare because each sweeps the
    // whole memory.
    task automatic random_phase(input int count, input int window);
        int      pick;
        int      row;
        int      col;
        int      rnd;
        int      gap;
        action_t act;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 42)
                act = ACT_ADD;
            else if (pick < 62)
                act = ACT_REMOVE;
            else if (pick < 97)
                act = ACT_COMPETE;
            else
                act = ACT_SNAPSHOT;
            if ($urandom_range(0, 3) == 0)
            begin
                row = $urandom_range(0, 127);
                col = $urandom_range(0, 127);
            end
            else
            begin
                row = $urandom_range(0, window - 1);
                col = $urandom_range(0, window - 1);
            end
            rnd = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 4095);
            // Long stretches run back to back; elsewhere the gap is drawn per item.
            gap = (n % 50 < 15) ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0)
            begin
                start <= 1'b0;
                wait_drained();
            end
            send_item(act, row, col, rnd, gap);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset settings: corners with wrap-around, a
        // repeated add, a remove and a competition test on empty cells, a
        // snapshot, competition tests that kill and one that must not, then removes.
        send_item(ACT_ADD,      0,   0,   0,     0);
        send_item(ACT_ADD,      0,   0,   0,     1);
        send_item(ACT_ADD,      127, 127, 65535, 0);
        send_item(ACT_ADD,      0,   1,   0,     2);
        send_item(ACT_REMOVE,   5,   5,   0,     0);
        send_item(ACT_COMPETE,  9,   9,   0,     3);
        send_item(ACT_SNAPSHOT, 127, 0,   0,     0);
        send_item(ACT_COMPETE,  0,   0,   0,     0);
        send_item(ACT_COMPETE,  0,   1,   65535, 1);
        send_item(ACT_COMPETE,  127, 127, 1,     0);
        send_item(ACT_REMOVE,   0,   1,   0,     0);
        send_item(ACT_REMOVE,   127, 127, 0,     0);

        // A single cell with the widest radius: every offset lands on the
        // cell itself, and the factor at its top makes the test after the snapshot kill.
        set_lattice(1, 1, 3, 65535);
        send_item(ACT_ADD,      100, 77,  0,     0);
        send_item(ACT_SNAPSHOT, 0,   0,   0,     0);
        send_item(ACT_COMPETE,  0,   0,   65535, 0);
        send_item(ACT_ADD,      3,   3,   0,     1);
        random_phase(40, 4);

        // Out-of-range settings clamp: zero columns, rows over the maximum,
        // zero radius, zero factor so that only a zero random value kills.
        set_lattice(255, 0, 0, 0);
        send_item(ACT_COMPETE, 4, 0, 0, 0);
        random_phase(50, 8);

        set_lattice(5, 7, 2, 2048);
        random_phase(70, 8);

        set_lattice(8, 8, 3, 40000);
        random_phase(70, 8);

        // Resizing keeps cells that now lie outside the lattice in use.
        set_lattice(3, 128, 1, 12000);
        random_phase(50, 16);

        set_lattice(128, 128, 3, 4096);
        random_phase(70, 12);

        set_lattice(128, 128, 1, 65535);
        random_phase(40, 6);

        start <= 1'b0;
        wait_drained();
        repeat (200) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
